>>> rtl/tmm_pkg.sv
// Shared constants, state encoding and command bundle for the tiled matrix multiplier.
package tmm_pkg;

	localparam int MATRIX_DIM = 8;
	localparam int ELEM_BITS  = 16;

	localparam int IN_W   = 16;
	localparam int ROW_W  = 3;
	localparam int OUT_W  = 35;
	localparam int ACC_W  = 36;
	localparam int TILE_W = 4;

	localparam int OPD_W     = (ELEM_BITS < IN_W) ? ELEM_BITS : IN_W;
	localparam int PROD_W    = 2 * OPD_W;
	localparam int NUM_ELEMS = MATRIX_DIM * MATRIX_DIM;
	localparam int IDX_W     = $clog2(MATRIX_DIM);
	localparam int ADDR_W    = $clog2(NUM_ELEMS);
	localparam int LCNT_W    = $clog2(NUM_ELEMS + 1);
	localparam int SUM_W     = ((IDX_W > TILE_W) ? IDX_W : TILE_W) + 1;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [TILE_W-1:0] TILE_RESET = TILE_W'(2);

	typedef enum logic [PADDR_W-3:0] {
		REG_TILE_SIZE = 1'b0
	} tmm_reg_t;

	typedef enum logic [6:0] {
		S_LOAD  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_MUL   = 7'b0000100,
		S_ACC   = 7'b0001000,
		S_ORD   = 7'b0010000,
		S_OLD   = 7'b0100000,
		S_OHOLD = 7'b1000000
	} tmm_state_t;

	typedef struct packed {
		logic              ld_we;
		logic [ADDR_W-1:0] ld_addr;
		logic              ab_re;
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
		logic              mul_en;
		logic              r_re;
		logic              acc_we;
		logic              acc_first;
		logic [ADDR_W-1:0] r_addr;
		logic              out_load;
		logic [ROW_W-1:0]  out_row;
		logic [ROW_W-1:0]  out_col;
		logic              out_last;
	} tmm_cmd_t;

endpackage

>>> rtl/tmm_if.sv
// Valid/ready channel interfaces for operand beats and result beats.
interface tmm_in_if;
	import tmm_pkg::*;

	logic            valid;
	logic            ready;
	logic [IN_W-1:0] a_value;
	logic [IN_W-1:0] b_value;
	logic            last_item;

	modport source (output valid, output a_value, output b_value, output last_item,
		input ready);
	modport sink (input valid, input a_value, input b_value, input last_item,
		output ready);
endinterface

interface tmm_out_if;
	import tmm_pkg::*;

	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_index;
	logic [ROW_W-1:0] col_index;
	logic [OUT_W-1:0] product_value;
	logic             last_result;

	modport source (output valid, output row_index, output col_index,
		output product_value, output last_result, input ready);
	modport sink (input valid, input row_index, input col_index,
		input product_value, input last_result, output ready);
endinterface

>>> rtl/tmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/tmm_datapath.sv
// Operand and result stores, multiplier, accumulator and result output register.
module tmm_datapath (
	input  logic                     clk,
	input  tmm_pkg::tmm_cmd_t        cmd,
	input  logic [tmm_pkg::IN_W-1:0] a_value,
	input  logic [tmm_pkg::IN_W-1:0] b_value,
	output logic [tmm_pkg::ROW_W-1:0] row_index,
	output logic [tmm_pkg::ROW_W-1:0] col_index,
	output logic [tmm_pkg::OUT_W-1:0] product_value,
	output logic                      last_result
);
	import tmm_pkg::*;

	logic [IN_W-1:0]   a_rd;
	logic [IN_W-1:0]   b_rd;
	logic [ACC_W-1:0]  r_rd;
	logic [ACC_W-1:0]  acc_sum;
	logic [PROD_W-1:0] prod_q;
	logic [OUT_W-1:0]  product_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  col_q;
	logic              last_q;

	tmm_ram #(.WIDTH(IN_W), .DEPTH(NUM_ELEMS)) u_a_ram (
		.clk   (clk),
		.we    (cmd.ld_we),
		.waddr (cmd.ld_addr),
		.wdata (a_value),
		.re    (cmd.ab_re),
		.raddr (cmd.a_addr),
		.rdata (a_rd)
	);

	tmm_ram #(.WIDTH(IN_W), .DEPTH(NUM_ELEMS)) u_b_ram (
		.clk   (clk),
		.we    (cmd.ld_we),
		.waddr (cmd.ld_addr),
		.wdata (b_value),
		.re    (cmd.ab_re),
		.raddr (cmd.b_addr),
		.rdata (b_rd)
	);

	// The first term of each element overwrites the old sum, so no clearing pass is needed.
	assign acc_sum = (cmd.acc_first ? ACC_W'(0) : r_rd) + ACC_W'(prod_q);

	tmm_ram #(.WIDTH(ACC_W), .DEPTH(NUM_ELEMS)) u_r_ram (
		.clk   (clk),
		.we    (cmd.acc_we),
		.waddr (cmd.r_addr),
		.wdata (acc_sum),
		.re    (cmd.r_re),
		.raddr (cmd.r_addr),
		.rdata (r_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= a_rd[OPD_W-1:0] * b_rd[OPD_W-1:0];
		end
		if (cmd.out_load) begin
			product_q <= r_rd[OUT_W-1:0];
			row_q     <= cmd.out_row;
			col_q     <= cmd.out_col;
			last_q    <= cmd.out_last;
		end
	end

	assign row_index     = row_q;
	assign col_index     = col_q;
	assign product_value = product_q;
	assign last_result   = last_q;
endmodule

>>> rtl/tmm_ctrl.sv
// Controller: load counting, tiled i-k-j walk and result streaming sequence.
module tmm_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_last,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  logic [tmm_pkg::TILE_W-1:0] tile_size,
	output tmm_pkg::tmm_cmd_t          cmd
);
	import tmm_pkg::*;

	localparam logic [SUM_W-1:0] DIM_S    = SUM_W'(MATRIX_DIM);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_DIM - 1);
	localparam logic [ADDR_W-1:0] DIM_A   = ADDR_W'(MATRIX_DIM);

	tmm_state_t        state_q;
	logic [LCNT_W-1:0] load_count_q;
	logic [TILE_W-1:0] tile_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q, i0_q, j0_q, k0_q;
	logic [IDX_W-1:0]  ni, nj, nk, ni0, nj0, nk0;
	logic              mac_done;
	logic              in_fire;
	logic [SUM_W-1:0]  t_s, i_end, j_end, k_end, i_lim, j_lim, k_lim;
	logic [SUM_W-1:0]  i0_next, j0_next, k0_next;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * DIM_A + ADDR_W'(c));
	endfunction

	assign in_fire = in_valid && in_ready;
	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OHOLD);

	assign t_s     = SUM_W'(tile_q);
	assign i0_next = SUM_W'(i0_q) + t_s;
	assign j0_next = SUM_W'(j0_q) + t_s;
	assign k0_next = SUM_W'(k0_q) + t_s;
	assign i_end   = i0_next;
	assign j_end   = j0_next;
	assign k_end   = k0_next;
	assign i_lim   = (i_end < DIM_S) ? i_end : DIM_S;
	assign j_lim   = (j_end < DIM_S) ? j_end : DIM_S;
	assign k_lim   = (k_end < DIM_S) ? k_end : DIM_S;

	always_comb begin
		mac_done = 1'b0;
		ni  = i_q;
		nj  = j_q;
		nk  = k_q;
		ni0 = i0_q;
		nj0 = j0_q;
		nk0 = k0_q;
		if (SUM_W'(j_q) + SUM_W'(1) < j_lim) begin
			nj = j_q + IDX_W'(1);
		end else begin
			nj = j0_q;
			if (SUM_W'(k_q) + SUM_W'(1) < k_lim) begin
				nk = k_q + IDX_W'(1);
			end else if (SUM_W'(i_q) + SUM_W'(1) < i_lim) begin
				nk = k0_q;
				ni = i_q + IDX_W'(1);
			end else if (k0_next < DIM_S) begin
				nk0 = IDX_W'(k0_next);
				nk  = IDX_W'(k0_next);
				ni  = i0_q;
			end else if (j0_next < DIM_S) begin
				nk0 = '0;
				nk  = '0;
				nj0 = IDX_W'(j0_next);
				nj  = IDX_W'(j0_next);
				ni  = i0_q;
			end else if (i0_next < DIM_S) begin
				nk0 = '0;
				nk  = '0;
				nj0 = '0;
				nj  = '0;
				ni0 = IDX_W'(i0_next);
				ni  = IDX_W'(i0_next);
			end else begin
				mac_done = 1'b1;
			end
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.ld_we     = in_fire && (load_count_q < LCNT_W'(NUM_ELEMS));
		cmd.ld_addr   = load_count_q[ADDR_W-1:0];
		cmd.a_addr    = addr_of(i_q, k_q);
		cmd.b_addr    = addr_of(k_q, j_q);
		cmd.r_addr    = addr_of(i_q, j_q);
		cmd.ab_re     = (state_q == S_READ);
		cmd.mul_en    = (state_q == S_MUL);
		cmd.acc_we    = (state_q == S_ACC);
		cmd.acc_first = (k_q == '0);
		cmd.r_re      = (state_q == S_READ) || (state_q == S_ORD);
		cmd.out_load  = (state_q == S_OLD);
		cmd.out_row   = ROW_W'(i_q);
		cmd.out_col   = ROW_W'(j_q);
		cmd.out_last  = (i_q == LAST_IDX) && (j_q == LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			load_count_q <= '0;
			tile_q       <= TILE_W'(1);
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			i0_q         <= '0;
			j0_q         <= '0;
			k0_q         <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (load_count_q < LCNT_W'(NUM_ELEMS)) begin
							load_count_q <= load_count_q + LCNT_W'(1);
						end
						if (in_last) begin
							tile_q  <= (tile_size == '0) ? TILE_W'(1) : tile_size;
							i_q     <= '0;
							j_q     <= '0;
							k_q     <= '0;
							i0_q    <= '0;
							j0_q    <= '0;
							k0_q    <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (mac_done) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_ORD;
					end else begin
						i_q     <= ni;
						j_q     <= nj;
						k_q     <= nk;
						i0_q    <= ni0;
						j0_q    <= nj0;
						k0_q    <= nk0;
						state_q <= S_READ;
					end
				end
				S_ORD: begin
					state_q <= S_OLD;
				end
				S_OLD: begin
					state_q <= S_OHOLD;
				end
				S_OHOLD: begin
					if (out_ready) begin
						if (cmd.out_last) begin
							load_count_q <= '0;
							state_q      <= S_LOAD;
						end else begin
							if (j_q == LAST_IDX) begin
								j_q <= '0;
								i_q <= i_q + IDX_W'(1);
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end
endmodule

>>> rtl/tiled_matrix_multiply_top.sv
// Top level of the tiled matrix multiplier: channels, register port, controller and datapath.
// Loading takes one cycle per operand beat; the beat marked last starts the multiply.
// Each multiply-accumulate of the multiply then steps through the read, multiply and
// write-back steps on the result store, N^3 of them in all (512 at N=8).
// Each result beat steps through read, load and hold, waiting for out_ready; 64 per multiply.
// Asynchronous active-low reset clears the controller, load count and tile size (to 2);
// the stores are not cleared and need no clearing pass.
module tiled_matrix_multiply_top (
	input  logic                        clk,
	input  logic                        arst_n,
	tmm_in_if.sink                      in_ch,
	tmm_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tmm_pkg::PADDR_W-1:0] paddr,
	input  logic [tmm_pkg::PDATA_W-1:0] pwdata,
	output logic [tmm_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import tmm_pkg::*;

	logic [TILE_W-1:0] tile_size_q;
	tmm_reg_t          reg_idx;
	logic              cfg_write;
	tmm_cmd_t          cmd;

	assign pready    = 1'b1;
	assign reg_idx   = tmm_reg_t'(paddr[PADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q <= TILE_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_TILE_SIZE: tile_size_q <= pwdata[TILE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TILE_SIZE: prdata = PDATA_W'(tile_size_q);
			default:       prdata = '0;
		endcase
	end

	tmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_item),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.tile_size (tile_size_q),
		.cmd       (cmd)
	);

	tmm_datapath u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.a_value       (in_ch.a_value),
		.b_value       (in_ch.b_value),
		.row_index     (out_ch.row_index),
		.col_index     (out_ch.col_index),
		.product_value (out_ch.product_value),
		.last_result   (out_ch.last_result)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("operand beat accepted while a result beat is pending");

	a_last_in_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.last_item) |=> !in_ch.ready)
		else $error("multiply did not start after the last operand beat");

	a_last_out_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last_result) |=> in_ch.ready)
		else $error("loading did not resume after the last result beat");

	a_no_result_while_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_we || cmd.mul_en) |-> !out_ch.valid)
		else $error("result beat shown during accumulation");
endmodule
